### src/audio_linear_upsampler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio linear upsampler
// Concurrent checks on clk; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LINEAR_UPSAMPLER_TOP_DEFINES_SVH
`define AUDIO_LINEAR_UPSAMPLER_TOP_DEFINES_SVH
`ifndef SYNTH
// check outside reset
`define AUP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define AUP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AUP_ASSERT(label, prop, msg)
`define AUP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### src/aup_pkg.sv
// ----------------------------------------------------------------------------
// aup_pkg
// Shared types, codes and helpers of the audio linear upsampler.
// ----------------------------------------------------------------------------
`default_nettype none
package aup_pkg;

  // rate_ratio codes; the unused code behaves as 1x
  typedef enum logic [1:0] {
    RATIO_1X = 2'd0,
    RATIO_2X = 2'd1,
    RATIO_4X = 2'd2
  } ratio_code_t;

  // sample_format codes; the unused code behaves as 16-bit
  typedef enum logic [1:0] {
    FMT_U8      = 2'd0,
    FMT_U8_S16  = 2'd1,
    FMT_S16     = 2'd2
  } format_code_t;

  // register index (address bit 2)
  localparam logic REG_RATIO  = 1'b0;
  localparam logic REG_FORMAT = 1'b1;

  localparam logic [7:0] BYTE_BIAS = 8'h80;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // live configuration
  typedef struct packed {
    logic [1:0] ratio;
    logic [1:0] format;
  } cfg_t;

  // one input word's run of results, as handed from front to back
  typedef struct packed {
    logic signed [15:0] a;       // held sample
    logic signed [15:0] b;       // current sample
    logic signed [15:0] m;       // midpoint of a and b
    logic [2:0]         run_n;   // interpolated words: 0, 2 or 4
    logic [2:0]         copy_n;  // copies of b: 0, 1, 2 or 4
    logic               eos;
  } run_t;

  // floor((x + y) / 2)
  function automatic logic signed [15:0] avg16(input logic signed [15:0] x,
                                               input logic signed [15:0] y);
    logic signed [16:0] s;
    s = 17'(x) + 17'(y);
    return s[16:1];
  endfunction

endpackage
`default_nettype wire

### src/aup_front.sv
// ----------------------------------------------------------------------------
// aup_front
// Accepts input words, converts them, tracks the held sample and queues
// one run descriptor for each word that produces results.
// ----------------------------------------------------------------------------
`default_nettype none
module aup_front import aup_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               push,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_end_of_sound,
  input  wire logic               q_full,
  output      logic               q_wr,
  output      run_t               q_data
);

  logic signed [15:0] held_sample_r, held_sample_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic signed [15:0] cur;
  logic               accept;
  logic               wide;      // 4x
  logic               interp;    // 2x or 4x
  logic [2:0]         ratio_n;

  assign accept = push && !q_full;

  // convert to output format
  always_comb begin
    case (cfg.format)
      FMT_U8:     cur = {8'h00, in_sample[7:0]};
      FMT_U8_S16: cur = {in_sample[7:0] ^ BYTE_BIAS, 8'h00};
      default:    cur = in_sample;
    endcase
  end

  // decode ratio
  always_comb begin
    case (cfg.ratio)
      RATIO_2X: begin
        interp = 1'b1;
        wide   = 1'b0;
      end
      RATIO_4X: begin
        interp = 1'b1;
        wide   = 1'b1;
      end
      default: begin
        interp = 1'b0;
        wide   = 1'b0;
      end
    endcase
  end

  assign ratio_n = wide ? 3'd4 : 3'd2;

  // build descriptor and next held state
  always_comb begin
    held_sample_nxt = held_sample_r;
    held_valid_nxt  = held_valid_r;
    q_data.a        = held_sample_r;
    q_data.b        = cur;
    q_data.m        = avg16(held_sample_r, cur);
    q_data.eos      = in_end_of_sound;
    q_data.run_n    = 3'd0;
    q_data.copy_n   = 3'd1;
    q_wr            = 1'b0;
    if (!interp) begin
      q_wr = accept;
      if (accept) begin
        held_valid_nxt = 1'b0;
      end
    end else begin
      q_data.run_n  = held_valid_r ? ratio_n : 3'd0;
      q_data.copy_n = in_end_of_sound ? ratio_n : 3'd0;
      q_wr          = accept && (held_valid_r || in_end_of_sound);
      if (accept) begin
        held_valid_nxt  = !in_end_of_sound;
        held_sample_nxt = in_end_of_sound ? 16'sd0 : cur;
      end
    end
  end

  // hold previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_sample_r <= 16'sd0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_sample_r <= held_sample_nxt;
    end
  end

endmodule
`default_nettype wire

### src/aup_queue.sv
// ----------------------------------------------------------------------------
// aup_queue
// Small descriptor queue between front and back, show-ahead head.
// ----------------------------------------------------------------------------
`default_nettype none
`include "audio_linear_upsampler_top_defines.svh"
module aup_queue import aup_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire run_t wr_data,
  output      logic full,
  input  wire logic rd_en,
  output      logic rd_valid,
  output      run_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store descriptor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  `AUP_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `AUP_ASSERT(a_no_write_full, full |-> !wr_en, "write into full queue")

endmodule
`default_nettype wire

### src/aup_back.sv
// ----------------------------------------------------------------------------
// aup_back
// Walks each queued run one word per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "audio_linear_upsampler_top_defines.svh"
module aup_back import aup_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire run_t               q_data,
  output      logic               q_pop,
  output      logic               empty,
  input  wire logic               pop,
  output      logic signed [15:0] out_sample,
  output      logic               out_last_in_run,
  output      logic               out_sound_done
);

  logic [2:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] sample_r;
  logic               last_r, done_r;
  logic [3:0]         total;
  logic               is_last;
  logic               load;
  logic signed [15:0] q1, q3, value;

  assign total   = {1'b0, q_data.run_n} + {1'b0, q_data.copy_n};
  assign is_last = ({1'b0, idx_r} == total - 4'd1);
  assign load    = q_valid && (!out_valid_r || pop);
  assign q_pop   = load && is_last;

  // quarter points from the midpoint
  assign q1 = avg16(q_data.a, q_data.m);
  assign q3 = avg16(q_data.m, q_data.b);

  // select word at idx
  always_comb begin
    if ({1'b0, idx_r} < {1'b0, q_data.run_n}) begin
      case (idx_r[1:0])
        2'd0:    value = q_data.a;
        2'd1:    value = (q_data.run_n == 3'd4) ? q1 : q_data.m;
        2'd2:    value = q_data.m;
        default: value = q3;
      endcase
    end else begin
      value = q_data.b;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 3'd0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= value;
      last_r   <= is_last;
      done_r   <= is_last && q_data.eos;
    end
  end

  assign empty           = !out_valid_r;
  assign out_sample      = sample_r;
  assign out_last_in_run = last_r;
  assign out_sound_done  = done_r;

  `AUP_ASSERT(a_pop_needs_head, q_pop |-> q_valid, "pop from empty queue")
  `AUP_ASSERT(a_idx_in_run, q_valid |-> ({1'b0, idx_r} < total), "index past run end")
  `AUP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
`default_nettype wire

### src/audio_linear_upsampler_top.sv
// ----------------------------------------------------------------------------
// audio_linear_upsampler_top
// Streaming 1x/2x/4x linear-interpolation upsampler with APB configuration.
// ----------------------------------------------------------------------------
//  channel   | handshake              | words
//  input     | push / full            | in_sample, in_end_of_sound
//  result    | empty / pop            | out_sample, out_last_in_run, out_sound_done
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  Each input word is taken while the queue is not full; its results leave the
//  back end one per cycle while pop keeps up with them. The descriptor queue
//  (QUEUE_DEPTH entries) lets the front keep accepting while the output register
//  waits on pop. A result passes the descriptor queue and the output register.
//  Reset is synchronous: queue, output valid flag and held sample are cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module audio_linear_upsampler_top import aup_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               push,
  output      logic               full,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_end_of_sound,
  // result words
  output      logic               empty,
  input  wire logic               pop,
  output      logic signed [15:0] out_sample,
  output      logic               out_last_in_run,
  output      logic               out_sound_done,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;
  logic q_wr, q_full, q_valid, q_pop;
  run_t q_in, q_out;

  // register write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_RATIO:  cfg_nxt.ratio  = pwdata[1:0];
        REG_FORMAT: cfg_nxt.format = pwdata[1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read
  always_comb begin
    case (paddr[2])
      REG_RATIO:  prdata = {30'd0, cfg_r.ratio};
      REG_FORMAT: prdata = {30'd0, cfg_r.format};
      default:    prdata = 32'd0;
    endcase
  end

  assign full = q_full;

  aup_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .push            (push),
    .in_sample       (in_sample),
    .in_end_of_sound (in_end_of_sound),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_data          (q_in)
  );

  aup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_in),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_out)
  );

  aup_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_sample      (out_sample),
    .out_last_in_run (out_last_in_run),
    .out_sound_done  (out_sound_done)
  );

endmodule
`default_nettype wire
